// ===== hdl/synth_frequency_register_planner_core_defines.svh =====
// Assertion macros shared by the frequency planner RTL.
`ifndef SYNTH_FREQUENCY_REGISTER_PLANNER_CORE_DEFINES_SVH
`define SYNTH_FREQUENCY_REGISTER_PLANNER_CORE_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is high.
`define SFRP_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfrp assertion failed");
// Next-cycle implication, disabled while reset is high.
`define SFRP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfrp assertion failed");
`else
`define SFRP_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define SFRP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/sfrp_pkg.sv =====
package sfrp_pkg;

  localparam int FREQ_W     = 28;
  localparam int XTAL_W     = 26;
  localparam int DIVIDEND_W = 46;
  localparam int DIVISOR_W  = 30;

  localparam logic [FREQ_W-1:0] FREQ_MIN = 28'd1000000;
  localparam logic [FREQ_W-1:0] FREQ_MAX = 28'd150000000;
  localparam logic [XTAL_W-1:0] XTAL_MIN = 26'd10000000;
  localparam logic [XTAL_W-1:0] XTAL_MAX = 26'd40000000;

  localparam logic [29:0] VCO_MAX_HZ = 30'd900000000;
  localparam logic [19:0] FRAC_DENOM = 20'd1048575;
  localparam logic [17:0] P1_OFFSET  = 18'd512;
  localparam logic [19:0] P3_PLL     = FRAC_DENOM;
  localparam logic [19:0] P3_SYNTH   = 20'd1;

  localparam logic [7:0] PLL_RESET_BYTE = 8'hA0;
  localparam logic [7:0] CLOCK_ON_BYTE  = 8'h4F;

  // Configuration register indexes.
  localparam logic [2:0] CFG_CRYSTAL       = 3'd0;
  localparam logic [2:0] CFG_PLL_BASE      = 3'd1;
  localparam logic [2:0] CFG_SYNTH_BASE    = 3'd2;
  localparam logic [2:0] CFG_PLL_RESET     = 3'd3;
  localparam logic [2:0] CFG_CLOCK_CONTROL = 3'd4;
  localparam logic [2:0] CFG_R_DIVIDER     = 3'd5;
  localparam logic [2:0] CFG_SOURCE_SELECT = 3'd6;

  // Positions within the eighteen-write run.
  localparam logic [4:0] SLOT_SYNTH_FIRST   = 5'd8;
  localparam logic [4:0] SLOT_PLL_RESET     = 5'd16;
  localparam logic [4:0] SLOT_CLOCK_CONTROL = 5'd17;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VCO_LOAD,
    ST_VCO_WAIT,
    ST_MUL,
    ST_XTAL_LOAD,
    ST_XTAL_WAIT,
    ST_FRAC_LOAD,
    ST_FRAC_WAIT,
    ST_WHOLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
    logic [DIVISOR_W-1:0]  remainder;
  } div_rsp_t;

  // One byte of an eight-word parameter block.
  function automatic logic [7:0] block_byte(input logic [2:0]  word,
                                            input logic [17:0] p1,
                                            input logic [19:0] p2,
                                            input logic [19:0] p3,
                                            input logic [6:0]  or_bits);
    logic [7:0] b;
    unique case (word)
      3'd0: b = p3[15:8];
      3'd1: b = p3[7:0];
      3'd2: b = {6'b0, p1[17:16]} | {1'b0, or_bits};
      3'd3: b = p1[15:8];
      3'd4: b = p1[7:0];
      3'd5: b = {p3[19:16], p2[19:16]};
      3'd6: b = p2[15:8];
      3'd7: b = p2[7:0];
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/sfrp_div.sv =====
module sfrp_div (
  input  logic               clk,
  input  logic               rst,
  input  sfrp_pkg::div_req_t req,
  output sfrp_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(sfrp_pkg::DIVIDEND_W + 1);
  localparam logic [CNT_W-1:0] STEPS = CNT_W'(sfrp_pkg::DIVIDEND_W);

  logic [sfrp_pkg::DIVIDEND_W-1:0] acc;
  logic [sfrp_pkg::DIVISOR_W-1:0]  rem;
  logic [sfrp_pkg::DIVISOR_W-1:0]  dsr;
  logic [CNT_W-1:0]                cnt;
  logic                            run;
  logic                            done;
  logic [sfrp_pkg::DIVISOR_W:0]    trial;
  logic [sfrp_pkg::DIVISOR_W:0]    diff;
  logic                            fits;

  // Restoring division: one quotient bit per cycle, the quotient shifting in
  // behind the dividend bits as they leave the accumulator.
  assign trial = {rem, acc[sfrp_pkg::DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign fits  = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= STEPS;
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (run) begin
      acc <= {acc[sfrp_pkg::DIVIDEND_W-2:0], fits};
      rem <= fits ? diff[sfrp_pkg::DIVISOR_W-1:0] : trial[sfrp_pkg::DIVISOR_W-1:0];
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = acc;
  assign rsp.remainder = rem;

endmodule

// ===== hdl/synth_frequency_register_planner_core.sv =====
// Channel  Handshake                  Payload
// in       in_valid / in_stall        frequency_hz
// out      out_valid / out_stall      register_address, register_data, last_write
// cfg      cfg_write                  cfg_index, cfg_data
//
// A new frequency keeps the input stalled after it is accepted, through
// three passes of the shared 46-step divider (each with a load state and
// a wait state), a multiply state, a state to split the scaled fraction and
// eighteen write transactions, one per cycle when the output is not stalled.
// A repeated frequency is accepted but produces no transactions.
// Synchronous active-high reset restores the register defaults and clears the
// stored frequency. Output stalls hold the write sequence; input is stalled
// whenever the planner is not idle.
`include "synth_frequency_register_planner_core_defines.svh"

module synth_frequency_register_planner_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [27:0] frequency_hz,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  register_address,
  output logic [7:0]  register_data,
  output logic        last_write,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [25:0] cfg_data
);

  logic [25:0] crystal_hz;
  logic [7:0]  pll_base_address;
  logic [7:0]  synth_base_address;
  logic [7:0]  pll_reset_address;
  logic [7:0]  clock_control_address;
  logic [6:0]  r_divider_bits;
  logic [5:0]  source_select_bits;
  logic [27:0] last_frequency;

  sfrp_pkg::state_t   state;
  sfrp_pkg::state_t   state_next;
  sfrp_pkg::div_req_t div_req;
  sfrp_pkg::div_rsp_t div_rsp;

  logic [27:0] freq;
  logic [9:0]  divider;
  logic [29:0] pll;
  logic [6:0]  mult;
  logic [25:0] xtal_rem;
  logic [19:0] num;
  logic [6:0]  whole;
  logic [19:0] p2;
  logic [4:0]  slot;

  logic [27:0] freq_clamped;
  logic [25:0] xtal_clamped;
  logic [37:0] product;
  logic [26:0] num_scaled;
  logic [20:0] split_sum;
  logic        split_carry;
  logic [6:0]  whole_next;
  logic [19:0] p2_next;
  logic [17:0] p1_pll;
  logic [17:0] p1_synth;
  logic [7:0]  write_address;
  logic [7:0]  write_data;
  logic        in_accept;
  logic        new_item;
  logic        out_free;
  logic        emit_load;

  always_comb begin
    priority if (frequency_hz < sfrp_pkg::FREQ_MIN) begin
      freq_clamped = sfrp_pkg::FREQ_MIN;
    end else if (frequency_hz > sfrp_pkg::FREQ_MAX) begin
      freq_clamped = sfrp_pkg::FREQ_MAX;
    end else begin
      freq_clamped = frequency_hz;
    end
  end

  always_comb begin
    priority if (crystal_hz < sfrp_pkg::XTAL_MIN) begin
      xtal_clamped = sfrp_pkg::XTAL_MIN;
    end else if (crystal_hz > sfrp_pkg::XTAL_MAX) begin
      xtal_clamped = sfrp_pkg::XTAL_MAX;
    end else begin
      xtal_clamped = crystal_hz;
    end
  end

  assign in_stall  = (state != sfrp_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign new_item  = in_accept && (freq_clamped != last_frequency);
  assign out_free  = !out_valid || !out_stall;
  assign emit_load = (state == sfrp_pkg::ST_EMIT) && out_free;

  sfrp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfrp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state)
      sfrp_pkg::ST_IDLE: begin
        if (new_item) state_next = sfrp_pkg::ST_VCO_LOAD;
      end
      sfrp_pkg::ST_VCO_LOAD: begin
        div_req.start    = 1'b1;
        div_req.dividend = sfrp_pkg::DIVIDEND_W'(sfrp_pkg::VCO_MAX_HZ);
        div_req.divisor  = sfrp_pkg::DIVISOR_W'(freq);
        state_next       = sfrp_pkg::ST_VCO_WAIT;
      end
      sfrp_pkg::ST_VCO_WAIT: begin
        if (div_rsp.done) state_next = sfrp_pkg::ST_MUL;
      end
      sfrp_pkg::ST_MUL: begin
        state_next = sfrp_pkg::ST_XTAL_LOAD;
      end
      sfrp_pkg::ST_XTAL_LOAD: begin
        div_req.start    = 1'b1;
        div_req.dividend = sfrp_pkg::DIVIDEND_W'(pll);
        div_req.divisor  = sfrp_pkg::DIVISOR_W'(xtal_clamped);
        state_next       = sfrp_pkg::ST_XTAL_WAIT;
      end
      sfrp_pkg::ST_XTAL_WAIT: begin
        if (div_rsp.done) state_next = sfrp_pkg::ST_FRAC_LOAD;
      end
      sfrp_pkg::ST_FRAC_LOAD: begin
        // Remainder times the fraction denominator, as a shift and a subtract.
        div_req.start    = 1'b1;
        div_req.dividend = {xtal_rem, 20'b0} - {20'b0, xtal_rem};
        div_req.divisor  = sfrp_pkg::DIVISOR_W'(xtal_clamped);
        state_next       = sfrp_pkg::ST_FRAC_WAIT;
      end
      sfrp_pkg::ST_FRAC_WAIT: begin
        if (div_rsp.done) state_next = sfrp_pkg::ST_WHOLE;
      end
      sfrp_pkg::ST_WHOLE: begin
        state_next = sfrp_pkg::ST_EMIT;
      end
      sfrp_pkg::ST_EMIT: begin
        if (emit_load && (slot == sfrp_pkg::SLOT_CLOCK_CONTROL)) begin
          state_next = sfrp_pkg::ST_IDLE;
        end
      end
      default: state_next = sfrp_pkg::ST_IDLE;
    endcase
  end

  assign product = 38'(divider) * 38'(freq);

  // The denominator is 2^20 - 1, so the bits of 128 * num above bit 19 give a
  // first quotient, and adding them back to the low bits leaves room for at
  // most one more denominator.
  assign num_scaled  = {num, 7'b0};
  assign split_sum   = {1'b0, num_scaled[19:0]} + {14'b0, num_scaled[26:20]};
  assign split_carry = (split_sum >= {1'b0, sfrp_pkg::FRAC_DENOM});
  assign whole_next  = num_scaled[26:20] + {6'b0, split_carry};
  assign p2_next     = split_carry ? 20'(split_sum - {1'b0, sfrp_pkg::FRAC_DENOM})
                                   : split_sum[19:0];

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (new_item) freq <= freq_clamped;
    if ((state == sfrp_pkg::ST_VCO_WAIT) && div_rsp.done) begin
      divider <= {div_rsp.quotient[9:1], 1'b0};
    end
    if (state == sfrp_pkg::ST_MUL) pll <= product[29:0];
    if ((state == sfrp_pkg::ST_XTAL_WAIT) && div_rsp.done) begin
      mult     <= div_rsp.quotient[6:0];
      xtal_rem <= div_rsp.remainder[25:0];
    end
    if ((state == sfrp_pkg::ST_FRAC_WAIT) && div_rsp.done) begin
      num <= div_rsp.quotient[19:0];
    end
    // The remainder of the split is the fractional P2 word directly.
    if (state == sfrp_pkg::ST_WHOLE) begin
      whole <= whole_next;
      p2    <= p2_next;
    end
  end

  assign p1_pll   = {4'b0, mult, 7'b0} + {11'b0, whole} - sfrp_pkg::P1_OFFSET;
  assign p1_synth = {1'b0, divider, 7'b0} - sfrp_pkg::P1_OFFSET;

  always_comb begin
    priority if (slot < sfrp_pkg::SLOT_SYNTH_FIRST) begin
      write_address = pll_base_address + {5'b0, slot[2:0]};
      write_data    = sfrp_pkg::block_byte(slot[2:0], p1_pll, p2, sfrp_pkg::P3_PLL, 7'b0);
    end else if (slot < sfrp_pkg::SLOT_PLL_RESET) begin
      write_address = synth_base_address + {5'b0, slot[2:0]};
      write_data    = sfrp_pkg::block_byte(slot[2:0], p1_synth, 20'b0,
                                           sfrp_pkg::P3_SYNTH, r_divider_bits);
    end else if (slot == sfrp_pkg::SLOT_PLL_RESET) begin
      write_address = pll_reset_address;
      write_data    = sfrp_pkg::PLL_RESET_BYTE;
    end else begin
      write_address = clock_control_address;
      write_data    = sfrp_pkg::CLOCK_ON_BYTE | {2'b0, source_select_bits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (new_item) begin
        slot <= '0;
      end else if (emit_load) begin
        slot <= slot + 1'b1;
      end
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      register_address <= write_address;
      register_data    <= write_data;
      last_write       <= (slot == sfrp_pkg::SLOT_CLOCK_CONTROL);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crystal_hz            <= 26'd25000000;
      pll_base_address      <= 8'd26;
      synth_base_address    <= 8'd42;
      pll_reset_address     <= 8'd177;
      clock_control_address <= 8'd16;
      r_divider_bits        <= '0;
      source_select_bits    <= '0;
      last_frequency        <= '0;
    end else begin
      if (new_item) last_frequency <= freq_clamped;
      if (cfg_write) begin
        unique case (cfg_index)
          sfrp_pkg::CFG_CRYSTAL:       crystal_hz            <= cfg_data;
          sfrp_pkg::CFG_PLL_BASE:      pll_base_address      <= cfg_data[7:0];
          sfrp_pkg::CFG_SYNTH_BASE:    synth_base_address    <= cfg_data[7:0];
          sfrp_pkg::CFG_PLL_RESET:     pll_reset_address     <= cfg_data[7:0];
          sfrp_pkg::CFG_CLOCK_CONTROL: clock_control_address <= cfg_data[7:0];
          sfrp_pkg::CFG_R_DIVIDER:     r_divider_bits        <= cfg_data[6:0];
          sfrp_pkg::CFG_SOURCE_SELECT: source_select_bits    <= cfg_data[5:0];
          default: ;
        endcase
      end
    end
  end

  `SFRP_ASSERT_IMPLY(a_div_done_in_wait, clk, rst, div_rsp.done,
                     (state == sfrp_pkg::ST_VCO_WAIT || state == sfrp_pkg::ST_XTAL_WAIT ||
                      state == sfrp_pkg::ST_FRAC_WAIT))
  `SFRP_ASSERT_IMPLY(a_emit_words_in_range, clk, rst, state == sfrp_pkg::ST_EMIT,
                     (slot <= sfrp_pkg::SLOT_CLOCK_CONTROL) && (p2 < sfrp_pkg::FRAC_DENOM) &&
                     (num < sfrp_pkg::FRAC_DENOM))
  `SFRP_ASSERT_NEXT(a_pll_below_vco_max, clk, rst, state == sfrp_pkg::ST_MUL,
                    pll <= sfrp_pkg::VCO_MAX_HZ)

endmodule
